FILE: hw/rtl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and the CORDIC arctangent table for the
// differential drive odometry unit.
// ----------------------------------------------------------------------------
package ddo_pkg;

  // encoder counter width; only the low CountWidth bits of a count take part
  localparam int CountWidth = 32;
  localparam int DeltaW     = 33;   // saturated, direction-applied difference

  localparam int CordicSteps = 16;
  localparam int IterW       = $clog2(CordicSteps);
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [33:0] OneQ30     = 34'sd1073741824;

  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;
  localparam int CfgRegW  = 24;
  localparam logic [CfgIdxW-1:0] CfgDistPerPulse = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgTurnPerPulse = CfgIdxW'(1);
  localparam logic [CfgRegW-1:0] DistPerPulseRst = 24'd745563;
  localparam logic [CfgRegW-1:0] TurnPerPulseRst = 24'd1215094;

  typedef struct packed {
    logic signed [DeltaW-1:0] dl;
    logic signed [DeltaW-1:0] dr;
  } delta_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
  } pose_t;

  // atan(2^-i) in binary angle units (2^32 per turn)
  function automatic logic [29:0] atan_lut(input logic [IterW-1:0] i);
    logic [29:0] r;
    case (i)
      4'd0:    r = 30'd536870912;
      4'd1:    r = 30'd316933406;
      4'd2:    r = 30'd167458907;
      4'd3:    r = 30'd85004756;
      4'd4:    r = 30'd42667331;
      4'd5:    r = 30'd21354465;
      4'd6:    r = 30'd10679838;
      4'd7:    r = 30'd5340245;
      4'd8:    r = 30'd2670163;
      4'd9:    r = 30'd1335087;
      4'd10:   r = 30'd667544;
      4'd11:   r = 30'd333772;
      4'd12:   r = 30'd166886;
      4'd13:   r = 30'd83443;
      4'd14:   r = 30'd41722;
      4'd15:   r = 30'd20861;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/differential_drive_odometry_unit.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry_unit
// Dead-reckoning pose tracker for a two-wheel differential drive.
// ----------------------------------------------------------------------------
// Input channel: present cumulative left/right encoder counts and wheel
// directions with push; the item is taken when push is high and full low.
// Result channel: while empty is low, pos_x/pos_y (Q16.16 cm, saturating)
// and heading (binary angle, 2^31 = pi) show the oldest pose; pop takes it.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i (0: distance per
// pulse, 1: turn per pulse) and cfg_data_i, low 24 bits kept; ready is
// always high. Write only while no item is in flight.
// The back end takes a new item only once the last pose is done, so its
// sequence (heading and travel multiplies, 16 CORDIC iterations, two rounded
// steps on one multiplier) sets the throughput.
// A two-entry delta queue and a two-entry result queue decouple both sides:
// input is taken while the back end works and while results wait. When the
// receiver stalls and the result queue is full, the back end holds and the
// delta queue fills, then full rises.
// Reset clears pose, heading, previous counts and queues, and loads the
// default scale registers.
// ----------------------------------------------------------------------------
module differential_drive_odometry_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic [31:0]                      left_count_i,
  input  logic [31:0]                      right_count_i,
  input  logic                             left_reverse_i,
  input  logic                             right_reverse_i,
  output logic                             empty,
  input  logic                             pop,
  output logic signed [31:0]               pos_x_o,
  output logic signed [31:0]               pos_y_o,
  output logic signed [31:0]               heading_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ddo_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [ddo_pkg::CfgDataW-1:0]     cfg_data_i
);
  import ddo_pkg::*;

  logic [CfgRegW-1:0] dpp_q, tpp_q;

  logic   fq_push, fq_full, dq_valid, dq_pop;
  delta_t fq_data, dq_data;
  logic   res_push, res_room;
  pose_t  res_data;

  // result queue
  pose_t      rq_mem_q [2];
  logic       rq_wr_q, rq_rd_q;
  logic [1:0] rq_cnt_q;
  logic       rq_pop;
  pose_t      rq_head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpp_q <= DistPerPulseRst;
      tpp_q <= TurnPerPulseRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgDistPerPulse: dpp_q <= cfg_data_i[CfgRegW-1:0];
        CfgTurnPerPulse: tpp_q <= cfg_data_i[CfgRegW-1:0];
        default: ;
      endcase
    end
  end

  ddo_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_o          (full),
    .left_count_i    (left_count_i),
    .right_count_i   (right_count_i),
    .left_reverse_i  (left_reverse_i),
    .right_reverse_i (right_reverse_i),
    .q_full_i        (fq_full),
    .q_push_o        (fq_push),
    .q_data_o        (fq_data)
  );

  ddo_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .data_i  (fq_data),
    .full_o  (fq_full),
    .pop_i   (dq_pop),
    .valid_o (dq_valid),
    .data_o  (dq_data)
  );

  ddo_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .dist_per_pulse_i (dpp_q),
    .turn_per_pulse_i (tpp_q),
    .q_valid_i        (dq_valid),
    .q_data_i         (dq_data),
    .q_pop_o          (dq_pop),
    .res_room_i       (res_room),
    .res_push_o       (res_push),
    .res_data_o       (res_data)
  );

  // back end starts an item only with room, so a push always finds a slot
  assign res_room = rq_cnt_q != 2'd2;
  assign empty    = rq_cnt_q == 2'd0;
  assign rq_pop   = pop & ~empty;
  assign rq_head  = rq_mem_q[rq_rd_q];

  assign pos_x_o   = rq_head.pos_x;
  assign pos_y_o   = rq_head.pos_y;
  assign heading_o = rq_head.heading;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= 1'b0;
      rq_rd_q  <= 1'b0;
      rq_cnt_q <= 2'd0;
    end else begin
      if (res_push) rq_wr_q <= ~rq_wr_q;
      if (rq_pop)   rq_rd_q <= ~rq_rd_q;
      if (res_push && !rq_pop) begin
        rq_cnt_q <= rq_cnt_q + 2'd1;
      end else if (rq_pop && !res_push) begin
        rq_cnt_q <= rq_cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) rq_mem_q[rq_wr_q] <= res_data;
  end

endmodule

FILE: hw/rtl/ddo_front.sv
// ----------------------------------------------------------------------------
// ddo_front
// Input side: takes encoder counts, forms the saturated wheel deltas against
// the previous counts, applies direction and hands them to the delta queue.
// ----------------------------------------------------------------------------
module ddo_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  logic [31:0]    left_count_i,
  input  logic [31:0]    right_count_i,
  input  logic           left_reverse_i,
  input  logic           right_reverse_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output ddo_pkg::delta_t q_data_o
);
  import ddo_pkg::*;

  logic [CountWidth-1:0] prev_left_q, prev_right_q;
  logic [CountWidth-1:0] cur_left, cur_right;
  logic signed [DeltaW-1:0] raw_l, raw_r;
  logic accept;

  // wrap-aware difference, read as two's complement, clipped to 32-bit range
  function automatic logic signed [DeltaW-1:0] count_delta(
    input logic [CountWidth-1:0] cur,
    input logic [CountWidth-1:0] prev
  );
    logic [CountWidth-1:0] u, mag;
    logic signed [DeltaW-1:0] r;
    u   = cur - prev;
    mag = ~u + 1'b1;
    if (u[CountWidth-1]) begin
      if (65'(mag) > 65'h0_8000_0000) begin
        r = 33'h1_8000_0000;
      end else begin
        r = ~(DeltaW'(mag)) + 33'd1;
      end
    end else if (65'(u) > 65'h0_7FFF_FFFF) begin
      r = 33'h0_7FFF_FFFF;
    end else begin
      r = DeltaW'(u);
    end
    return r;
  endfunction

  assign cur_left  = CountWidth'(left_count_i);
  assign cur_right = CountWidth'(right_count_i);
  assign raw_l     = count_delta(cur_left, prev_left_q);
  assign raw_r     = count_delta(cur_right, prev_right_q);

  assign full_o   = q_full_i;
  assign accept   = push_i & ~q_full_i;
  assign q_push_o = accept;
  assign q_data_o.dl = left_reverse_i  ? -raw_l : raw_l;
  assign q_data_o.dr = right_reverse_i ? -raw_r : raw_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_left_q  <= '0;
      prev_right_q <= '0;
    end else if (accept) begin
      prev_left_q  <= cur_left;
      prev_right_q <= cur_right;
    end
  end

endmodule

FILE: hw/rtl/ddo_queue.sv
// ----------------------------------------------------------------------------
// ddo_queue
// Two-entry queue of wheel deltas between the front and the back.
// ----------------------------------------------------------------------------
module ddo_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ddo_pkg::delta_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output ddo_pkg::delta_t data_o
);
  import ddo_pkg::*;

  delta_t     mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

FILE: hw/rtl/ddo_back.sv
// ----------------------------------------------------------------------------
// ddo_back
// Pose update: heading accumulate, travel product, 16-step iterative CORDIC,
// rounded position steps on one shared multiplier, saturating accumulate.
// ----------------------------------------------------------------------------
module ddo_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [23:0]          dist_per_pulse_i,
  input  logic [23:0]          turn_per_pulse_i,
  input  logic                 q_valid_i,
  input  ddo_pkg::delta_t      q_data_i,
  output logic                 q_pop_o,
  input  logic                 res_room_i,
  output logic                 res_push_o,
  output ddo_pkg::pose_t       res_data_o
);
  import ddo_pkg::*;

  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] STurn = 4'd1;
  localparam logic [3:0] SDist = 4'd2;
  localparam logic [3:0] SRot  = 4'd3;
  localparam logic [3:0] SCEnd = 4'd4;
  localparam logic [3:0] SMHi  = 4'd5;
  localparam logic [3:0] SMLo  = 4'd6;
  localparam logic [3:0] SSum  = 4'd7;
  localparam logic [3:0] SSat  = 4'd8;
  localparam logic [3:0] SDone = 4'd9;

  logic [3:0] state_q, state_d;

  logic signed [DeltaW-1:0] dl_q, dr_q;
  logic [31:0]        angle_q;
  logic signed [31:0] x_q, y_q;
  logic signed [57:0] dist_q;
  logic [56:0]        ud_q;
  logic               dneg_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic [IterW-1:0]   iter_q;
  logic               flip_q;
  logic [30:0]        mc_q, ms_q;
  logic               cneg_q, sneg_q;
  logic               axis_q;
  logic [59:0]        phi_q;
  logic [58:0]        plo_q;
  logic signed [48:0] step_q;

  // combinational helpers
  logic signed [33:0] diff34, sum34;
  logic [55:0]        tprod;
  logic signed [58:0] dprod;
  logic [31:0]        rot_a;
  logic               rot_flip;
  logic signed [33:0] xs, ys, atan_v;
  logic signed [33:0] cfin, sfin, cclp, sclp;
  logic [28:0]        mul_a;
  logic [30:0]        mul_b;
  logic [59:0]        mul_p;
  logic [60:0]        frac_sum;
  logic [48:0]        qmag;
  logic               step_neg;
  logic signed [31:0] sat_base;
  logic signed [49:0] sat_sum;
  logic signed [31:0] sat_res;

  assign diff34 = 34'(dr_q) - 34'(dl_q);
  assign sum34  = 34'(dl_q) + 34'(dr_q);
  assign tprod  = diff34[31:0] * turn_per_pulse_i;
  assign dprod  = sum34 * $signed({1'b0, dist_per_pulse_i});

  // fold quadrants 1 and 2 onto 3 and 0, undone by negation at the end
  assign rot_flip = (angle_q[31:30] == 2'b01) || (angle_q[31:30] == 2'b10);
  assign rot_a    = rot_flip ? angle_q + 32'h8000_0000 : angle_q;

  assign xs     = cx_q >>> iter_q;
  assign ys     = cy_q >>> iter_q;
  assign atan_v = 34'(atan_lut(iter_q));

  assign cfin = flip_q ? -cx_q : cx_q;
  assign sfin = flip_q ? -cy_q : cy_q;
  assign cclp = (cfin > OneQ30) ? OneQ30 : ((cfin < -OneQ30) ? -OneQ30 : cfin);
  assign sclp = (sfin > OneQ30) ? OneQ30 : ((sfin < -OneQ30) ? -OneQ30 : sfin);

  // shared multiplier: high then low slice of |D| by |cos| or |sin|
  assign mul_b = axis_q ? ms_q : mc_q;
  assign mul_a = (state_q == SMHi) ? ud_q[56:28] : {1'b0, ud_q[27:0]};
  assign mul_p = mul_a * mul_b;

  // round to nearest on the magnitude, ties away from zero
  assign frac_sum = (61'(phi_q[10:0]) << 28) + 61'(plo_q) + (61'd1 << 38);
  assign qmag     = 49'(phi_q >> 11) + 49'(frac_sum >> 39);
  assign step_neg = dneg_q ^ (axis_q ? sneg_q : cneg_q);

  assign sat_base = axis_q ? y_q : x_q;
  assign sat_sum  = 50'(sat_base) + 50'(step_q);
  assign sat_res  = (sat_sum > 50'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                    (sat_sum < -50'sh8000_0000) ? 32'sh8000_0000 : 32'(sat_sum);

  assign q_pop_o    = (state_q == SIdle) & q_valid_i & res_room_i;
  assign res_push_o = (state_q == SDone);
  assign res_data_o.pos_x   = x_q;
  assign res_data_o.pos_y   = y_q;
  assign res_data_o.heading = angle_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: if (q_valid_i && res_room_i) state_d = STurn;
      STurn: state_d = SDist;
      SDist: state_d = SRot;
      SRot:  if (iter_q == IterW'(CordicSteps - 1)) state_d = SCEnd;
      SCEnd: state_d = SMHi;
      SMHi:  state_d = SMLo;
      SMLo:  state_d = SSum;
      SSum:  state_d = SSat;
      SSat:  state_d = axis_q ? SDone : SMHi;
      SDone: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      angle_q <= '0;
      x_q     <= '0;
      y_q     <= '0;
      iter_q  <= '0;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        STurn: angle_q <= angle_q + tprod[31:0];
        SDist: iter_q  <= '0;
        SRot:  iter_q  <= iter_q + 1'b1;
        SCEnd: axis_q  <= 1'b0;
        SSat: begin
          if (axis_q) begin
            y_q <= sat_res;
          end else begin
            x_q    <= sat_res;
            axis_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      SIdle: begin
        dl_q <= q_data_i.dl;
        dr_q <= q_data_i.dr;
      end
      SDist: begin
        dist_q <= 58'(dprod);
        flip_q <= rot_flip;
        cz_q   <= 34'($signed(rot_a));
        cx_q   <= CordicGain;
        cy_q   <= '0;
      end
      SRot: begin
        ud_q   <= dist_q[57] ? 57'(-dist_q) : 57'(dist_q);
        dneg_q <= dist_q[57];
        if (!cz_q[33]) begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - atan_v;
        end else begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + atan_v;
        end
      end
      SCEnd: begin
        cneg_q <= cclp[33];
        sneg_q <= sclp[33];
        mc_q   <= cclp[33] ? 31'(-cclp) : 31'(cclp);
        ms_q   <= sclp[33] ? 31'(-sclp) : 31'(sclp);
      end
      SMHi: phi_q  <= mul_p;
      SMLo: plo_q  <= 59'(mul_p);
      SSum: step_q <= step_neg ? -$signed(qmag) : $signed(qmag);
      default: ;
    endcase
  end

endmodule
